// ----- rtl/core/move_to_front_label_checker_defines.svh -----
// Assertion macros used by the checker RTL.
`ifndef MOVE_TO_FRONT_LABEL_CHECKER_DEFINES_SVH
`define MOVE_TO_FRONT_LABEL_CHECKER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define MTFLC_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define MTFLC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mtflc_pkg.sv -----
package mtflc_pkg;

  localparam int unsigned LABEL_W  = 7;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned ITEM_W   = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // List length; the 7-bit item, label and position fields are sized for it.
  localparam int unsigned MAX_ITEMS = 64;

  localparam logic [COUNT_W-1:0] CUP_COUNT_RST = 7'd64;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FAILED   = 2'd2,
    ST_RANGE    = 2'd3
  } mtflc_status_e;

  // Broadcast from the controller to every cell of the list.
  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [LABEL_W-1:0] label;
    logic               apply;
  } mtflc_bcast_t;

endpackage

// ----- rtl/core/mtflc_cell.sv -----
module mtflc_cell
  import mtflc_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtflc_bcast_t       bcast_i,
  input  logic [IW-1:0]      prev_item_i,
  input  logic [LABEL_W-1:0] prev_label_i,
  output logic [IW-1:0]      item_o,
  output logic [LABEL_W-1:0] label_o,
  output logic               hit_o,
  output logic               claim_o
);

  logic [IW-1:0]      item_q, item_d;
  logic [LABEL_W-1:0] label_q, label_d;
  logic               load;

  // Cells up to and including the addressed one take their neighbour's entry.
  assign hit_o   = (32'(bcast_i.pos) == IDX + 1);
  assign load    = bcast_i.apply && (32'(bcast_i.pos) >= IDX + 1);
  // Label already held here by an item other than the addressed one.
  assign claim_o = (label_q == bcast_i.label) && !hit_o;

  always_comb begin
    item_d  = item_q;
    label_d = label_q;
    if (load) begin
      item_d  = prev_item_i;
      label_d = prev_label_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q  <= IW'(IDX + 1);
      label_q <= '0;
    end else begin
      item_q  <= item_d;
      label_q <= label_d;
    end
  end

  assign item_o  = item_q;
  assign label_o = label_q;

endmodule

// ----- rtl/core/move_to_front_label_checker.sv -----
// Move-to-front label checker.
// Input stream s_axis carries one request per transaction: a label and a
// one-based position into the current item list. Output stream m_axis returns
// one result per request: the item found and a status (ok, conflict now,
// failed earlier, request out of range). Item 0 is reported unless ok.
// cup_count is written through cfg_we_i/cfg_wdata_i; the user must do so only while no
// request is in flight, as the block does not enforce this. It limits the positions that may be addressed.
// Each request is resolved in the cycle it is accepted: every list cell
// compares its rank and its label in parallel, the found item and conflict
// flag are reduced over the row, and on success the cells up to the addressed
// one shift by one towards the back while the found item enters at the front.
// The result is valid in the cycle after acceptance, and one
// request is taken every cycle while the receiver keeps up.
// A result held by a stalled receiver blocks only the next acceptance; the
// request side is ready whenever the output register is empty or draining.
// Reset restores item i at rank i, clears all labels and the sticky failure,
// sets cup_count to 64 and empties the output register.
`include "move_to_front_label_checker_defines.svh"

module move_to_front_label_checker
  import mtflc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,   // cup_count
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // [6:0] label, [13:7] position, [15:14] zero
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata   // [6:0] item_found, [8:7] status, [15:9] zero
);

  localparam int unsigned IW = $clog2(MAX_ITEMS + 1);

  logic [COUNT_W-1:0]  cup_count_q;
  logic                failed_q, failed_d;
  logic                out_valid_q, out_valid_d;
  logic [ITEM_W-1:0]   out_item_q, out_item_d;
  mtflc_status_e       out_status_q, out_status_d;

  logic [LABEL_W-1:0]  in_label;
  logic [POS_W-1:0]    in_pos;
  logic                accept;
  logic                out_of_range;
  logic                conflict;
  logic                claim_any;
  logic [IW-1:0]       found_item;
  logic [LABEL_W-1:0]  found_label;
  mtflc_bcast_t        bcast;

  logic [IW-1:0]       cell_item  [MAX_ITEMS];
  logic [LABEL_W-1:0]  cell_label [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_hit;
  logic [MAX_ITEMS-1:0] cell_claim;

  assign in_label = s_axis_tdata[LABEL_W-1:0];
  assign in_pos   = s_axis_tdata[LABEL_W+POS_W-1:LABEL_W];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign out_of_range = (in_pos == '0) || (32'(in_pos) > 32'(cup_count_q)) ||
                        (32'(in_pos) > MAX_ITEMS) || (in_label == '0) ||
                        (32'(in_label) > MAX_ITEMS);

  // Reduce the row: at most one cell matches the position.
  always_comb begin
    found_item  = '0;
    found_label = '0;
    for (int unsigned i = 0; i < MAX_ITEMS; i++) begin
      if (cell_hit[i]) begin
        found_item  = found_item | cell_item[i];
        found_label = found_label | cell_label[i];
      end
    end
  end

  assign claim_any = |cell_claim;
  assign conflict  = ((found_label != '0) && (found_label != in_label)) || claim_any;

  assign bcast.pos   = in_pos;
  assign bcast.label = in_label;
  assign bcast.apply = accept && !failed_q && !out_of_range && !conflict;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    logic [IW-1:0]      prev_item;
    logic [LABEL_W-1:0] prev_label;

    if (g == 0) begin : g_head
      assign prev_item  = found_item;
      assign prev_label = in_label;
    end else begin : g_body
      assign prev_item  = cell_item[g-1];
      assign prev_label = cell_label[g-1];
    end

    mtflc_cell #(
      .IDX (g),
      .IW  (IW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .bcast_i      (bcast),
      .prev_item_i  (prev_item),
      .prev_label_i (prev_label),
      .item_o       (cell_item[g]),
      .label_o      (cell_label[g]),
      .hit_o        (cell_hit[g]),
      .claim_o      (cell_claim[g])
    );
  end

  always_comb begin
    failed_d     = failed_q;
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;
    out_status_d = out_status_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      out_item_d  = '0;
      if (failed_q) begin
        out_status_d = ST_FAILED;
      end else if (out_of_range) begin
        out_status_d = ST_RANGE;
      end else if (conflict) begin
        out_status_d = ST_CONFLICT;
        failed_d     = 1'b1;
      end else begin
        out_status_d = ST_OK;
        out_item_d   = ITEM_W'(found_item);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cup_count_q <= CUP_COUNT_RST;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cup_count_q <= cfg_wdata_i;
      end
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q   <= out_item_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_status_q, out_item_q};

  `MTFLC_ASSERT_NEXT(a_failed_sticky, clk_i, rst_ni, failed_q, failed_q,
    "sticky failure cleared")
  `MTFLC_ASSERT_NOW(a_ok_has_item, clk_i, rst_ni,
    m_axis_tvalid && (out_status_q == ST_OK), out_item_q != '0,
    "ok result without an item")
  `MTFLC_ASSERT_NOW(a_single_hit, clk_i, rst_ni, accept && !out_of_range,
    $onehot(cell_hit), "addressed rank not held by exactly one cell")
  `MTFLC_ASSERT_NEXT(a_front_update, clk_i, rst_ni, bcast.apply,
    cell_item[0] == $past(found_item), "found item not moved to the front")
  `MTFLC_ASSERT_NEXT(a_failed_report, clk_i, rst_ni, accept && failed_q,
    m_axis_tvalid && (out_status_q == ST_FAILED), "earlier failure not reported")

endmodule

// ----- bench/tb_move_to_front_label_checker.sv -----
module tb_move_to_front_label_checker;
  import mtflc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_LEN  = MAX_ITEMS;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned IDLE_MAX  = 4000;

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    mtflc_status_e     status;
  } lookup_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata  = '0;   // [6:0] label, [13:7] position, [15:14] zero
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;         // [6:0] item_found, [8:7] status, [15:9] zero

  // Predictor state
  logic [ITEM_W-1:0]  list_order [LIST_LEN];
  logic [LABEL_W-1:0] held_label [1:LIST_LEN];
  logic [ITEM_W-1:0]  owner_item [1:LIST_LEN];
  logic               sticky_fail;
  logic [COUNT_W-1:0] cup_count_model;

  lookup_result_t pending_lookups [$];
  int unsigned    fail_count     = 0;
  int unsigned    burst_left     = 0;
  bit             sender_gaps_on = 1'b0;
  int unsigned    stall_pct      = 0;
  bit             stall_pattern_on = 1'b0;
  bit             hold_req       = 1'b0;

  move_to_front_label_checker u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Look up the item at a rank, check its pairing and move it to the front.
  function automatic lookup_result_t predict_lookup(input logic [LABEL_W-1:0] label,
                                                    input logic [POS_W-1:0] pos);
    lookup_result_t    res;
    int unsigned       lim;
    logic [ITEM_W-1:0] found;
    res.item = '0;
    lim = (cup_count_model > LIST_LEN) ? LIST_LEN : cup_count_model;
    if (sticky_fail) begin
      res.status = ST_FAILED;
    end else if (pos == 0 || pos > lim || label == 0 || label > LIST_LEN) begin
      res.status = ST_RANGE;
    end else begin
      found = list_order[pos-1];
      if ((held_label[found] != 0 && held_label[found] != label) ||
          (owner_item[label] != 0 && owner_item[label] != found)) begin
        sticky_fail = 1'b1;
        res.status = ST_CONFLICT;
      end else begin
        held_label[found] = label;
        owner_item[label] = found;
        for (int i = pos - 1; i > 0; i--) list_order[i] = list_order[i-1];
        list_order[0] = found;
        res.item = found;
        res.status = ST_OK;
      end
    end
    return res;
  endfunction

  // Label that keeps the pairing one-to-one for the item now at this rank.
  function automatic logic [LABEL_W-1:0] agreeing_label(input logic [POS_W-1:0] pos);
    logic [ITEM_W-1:0] found;
    int unsigned       start;
    int unsigned       cand;
    found = list_order[pos-1];
    if (held_label[found] != 0) return held_label[found];
    start = $urandom_range(0, LIST_LEN - 1);
    for (int k = 0; k < LIST_LEN; k++) begin
      cand = (start + k) % LIST_LEN + 1;
      if (owner_item[cand] == 0) return cand[LABEL_W-1:0];
    end
    return LABEL_W'(1);
  endfunction

  task automatic send_request(input logic [LABEL_W-1:0] label, input logic [POS_W-1:0] pos);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (sender_gaps_on) begin
        gap = $urandom_range(1, 8);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, pos, label};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    pending_lookups = {pending_lookups, predict_lookup(label, pos)};
    burst_left--;
  endtask

  // Hold the input idle until every result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_cup_count(input logic [COUNT_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cup_count_model = value;
  endtask

  task automatic send_random_request();
    int unsigned        lim;
    logic [POS_W-1:0]   pos;
    logic [LABEL_W-1:0] label;
    lim = (cup_count_model > LIST_LEN) ? LIST_LEN : cup_count_model;
    if (lim != 0 && $urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 9))
        0:       pos = POS_W'(1);
        1:       pos = POS_W'(lim);
        default: pos = POS_W'($urandom_range(1, lim));
      endcase
      label = agreeing_label(pos);
    end else begin
      // Out-of-range noise only: a bad label at a valid rank would be a conflict.
      pos   = POS_W'($urandom_range(0, 127));
      label = LABEL_W'($urandom_range(0, 127));
      case ($urandom_range(0, 3))
        0:       pos = '0;
        1:       pos = POS_W'($urandom_range(lim + 1, 127));
        2:       label = '0;
        default: label = LABEL_W'($urandom_range(LIST_LEN + 1, 127));
      endcase
    end
    send_request(label, pos);
  endtask

  task automatic test_directed_extremes();
    sender_gaps_on = 1'b0;
    stall_pct = 0;
    send_request(7'd64, 7'd64);
    send_request(7'd64, 7'd1);
    send_request(7'd1, 7'd2);
    send_request(7'd5, 7'd0);
    send_request(7'd5, 7'd65);
    send_request(7'd127, 7'd127);
    send_request(7'd0, 7'd3);
    send_request(7'd65, 7'd3);
    send_request(7'd127, 7'd3);
    send_request(agreeing_label(7'd64), 7'd64);
    send_request(agreeing_label(7'd32), 7'd32);
    send_request(agreeing_label(7'd1), 7'd1);
    send_request(agreeing_label(7'd63), 7'd63);
  endtask

  task automatic test_cup_count_limits();
    write_cup_count(7'd1);
    send_request(agreeing_label(7'd1), 7'd1);
    send_request(7'd1, 7'd2);
    write_cup_count(7'd0);
    send_request(7'd1, 7'd1);
    send_request(7'd64, 7'd0);
    write_cup_count(7'd127);
    send_request(agreeing_label(7'd64), 7'd64);
    send_request(7'd3, 7'd65);
    send_request(7'd3, 7'd127);
  endtask

  task automatic test_random_traffic();
    logic [COUNT_W-1:0] seg_cup [8];
    seg_cup = '{7'd64, 7'd1, 7'd2, 7'd16, 7'd63, 7'd127, 7'd5, 7'd64};
    for (int seg = 0; seg < 8; seg++) begin
      write_cup_count(seg_cup[seg]);
      // First segment runs with no idling on either side.
      sender_gaps_on   = (seg != 0) && ($urandom_range(0, 3) != 0);
      stall_pct        = (seg == 0) ? 0 : $urandom_range(0, 70);
      stall_pattern_on = (seg != 0) && $urandom_range(0, 1);
      repeat (150) send_random_request();
    end
    stall_pattern_on = 1'b0;
  endtask

  task automatic test_backpressure();
    drain_results();
    sender_gaps_on = 1'b0;
    stall_pct = 20;
    hold_req = 1'b1;
    repeat (40) send_random_request();
    drain_results();
  endtask

  task automatic test_conflict_and_sticky();
    write_cup_count(7'd64);
    sender_gaps_on = 1'b1;
    stall_pct = 30;
    // Make sure the front item carries a label.
    send_request(agreeing_label(7'd1), 7'd1);
    drain_results();
    if ($urandom_range(0, 1)) begin
      // front item claims a label other than its own
      send_request(LABEL_W'(held_label[list_order[0]] % LIST_LEN + 1), 7'd1);
    end else begin
      // the front item's label claimed by the item behind it
      send_request(held_label[list_order[0]], 7'd2);
    end
    send_request(agreeing_label(7'd3), 7'd3);
    send_request(7'd0, 7'd0);
    repeat (12) send_request(LABEL_W'($urandom_range(0, 127)), POS_W'($urandom_range(0, 127)));
  endtask

  // Result checker
  initial begin
    lookup_result_t    exp_res;
    logic [ITEM_W-1:0] got_item;
    logic [1:0]        got_status;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got_item   = m_axis_tdata[6:0];
        got_status = m_axis_tdata[8:7];
        if (pending_lookups.size() == 0) begin
          $error("unexpected result transaction: item_found %0d status %0d",
                 got_item, got_status);
          fail_count++;
        end else begin
          exp_res = pending_lookups.pop_front();
          if (got_item !== exp_res.item) begin
            $error("item_found mismatch: expected %0d, actual %0d", exp_res.item, got_item);
            fail_count++;
          end
          if (got_status !== exp_res.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_res.status, got_status);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off on request.
  initial begin
    int unsigned rx_cycle;
    int unsigned hold_cnt;
    rx_cycle = 0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < LONG_HOLD) begin
          @(negedge clk_i);
          hold_cnt++;
        end
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct) &&
                         !(stall_pattern_on && (rx_cycle % 5 == 0));
      end
    end
  end

  // Watchdog: stop if nothing moves on either side for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_MAX) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("move_to_front_label_checker verification failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < LIST_LEN; i++) begin
      list_order[i]   = ITEM_W'(i + 1);
      held_label[i+1] = '0;
      owner_item[i+1] = '0;
    end
    sticky_fail     = 1'b0;
    cup_count_model = CUP_COUNT_RST;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_extremes();
    test_cup_count_limits();
    test_random_traffic();
    test_backpressure();
    test_conflict_and_sticky();

    drain_results();
    if (fail_count == 0)
      $display("move_to_front_label_checker verification clean");
    else
      $display("move_to_front_label_checker verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/mtflc_pkg.sv
rtl/core/mtflc_cell.sv
rtl/core/move_to_front_label_checker.sv
bench/tb_move_to_front_label_checker.sv
